// ===== rtl/tta_pkg.sv =====
// Shared constants, types and helpers for the tensor tile address generator.
package tta_pkg;

   localparam int NUM_AXES  = 4;    // axes walked, 1 to 8
   localparam int REG_AXES  = 4;    // axes with size/repeat registers
   localparam int EXT_W     = 13;   // size and repeat register width
   localparam int CNT_W     = 12;   // coordinate and repeat counter width
   localparam int IDX_W     = 32;   // flat index width
   localparam int CSR_IDX_W = 8;
   localparam int REQ_W     = 8;    // request tdata, restart bit padded to a byte
   localparam int RSP_W     = 2 * IDX_W;

   // register map: sizes first, then repeat counts
   localparam logic [CSR_IDX_W-1:0] REG_DIM_BASE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_REP_BASE = CSR_IDX_W'(REG_AXES);
   localparam logic [CSR_IDX_W-1:0] REG_END      = CSR_IDX_W'(2 * REG_AXES);

   localparam logic [EXT_W-1:0] MAX_EXTENT = EXT_W'(4096);

   // settle counter load value: strides and partial products are rebuilt after a write
   localparam int SETTLE_CYCLES = NUM_AXES + 1;
   localparam int SETTLE_W      = $clog2(SETTLE_CYCLES + 1);

   // status codes carried on rsp_tuser
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_DONE = 1'b1;

   typedef logic [EXT_W-1:0] ext_type;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [IDX_W-1:0] idx_type;

   // effective geometry handed from the register block to the walker
   typedef struct packed {
      logic                        busy;
      ext_type [NUM_AXES-1:0]      dim;
      ext_type [NUM_AXES-1:0]      rep;
      idx_type [NUM_AXES-1:0]      stride;
   } geom_type;

   typedef struct packed {
      idx_type dest_index;
      idx_type src_index;
      logic    is_last;
      logic    status;
   } result_type;

   function automatic ext_type clamp_extent(input ext_type v);
      ext_type r;
      if (v == '0) begin
         r = EXT_W'(1);
      end else if (v > MAX_EXTENT) begin
         r = MAX_EXTENT;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// ===== rtl/tensor_tile_address_generator.sv =====
// Top level of the tensor tile address generator: request and result registers.
//
//  channel  direction  beat carries
//  req_     in         tdata[0] restart
//  rsp_     out        tdata[31:0] dest_index, tdata[63:32] src_index,
//                      tlast is_last, tuser status
//  csr_     in         index (0..3 sizes, 4..7 repeats), data 13 bits
//
// One request beat per cycle while rsp_ is not stalled and no settle is running; its result
// passes the request register, then the result register, with the counter update between.
// Reset clears the walk and holds req_tready low while the stride chain settles;
// every csr write causes the same settle period.
// A stalled rsp_ keeps one result held and one request queued, then stops req_.
module tensor_tile_address_generator
   import tta_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [REQ_W-1:0]     req_tdata,   // [0] restart, rest zero
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RSP_W-1:0]     rsp_tdata,   // [31:0] dest_index, [63:32] src_index
   output logic                 rsp_tlast,
   output logic                 rsp_tuser,   // [0] status
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [EXT_W-1:0]     csr_data
);

   geom_type   geom;
   result_type result;
   logic       in_valid_ff, in_restart_ff;
   logic       out_valid_ff;
   result_type out_ff;
   logic       advance;

   assign csr_ready = 1'b1;

   tta_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .geom      (geom)
   );

   tta_walk u_walk (
      .clock   (clock),
      .reset   (reset),
      .geom    (geom),
      .step    (advance),
      .restart (in_restart_ff),
      .result  (result)
   );

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !geom.busy && (!in_valid_ff || advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_restart_ff <= req_tdata[0];
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.src_index, out_ff.dest_index};
   assign rsp_tlast  = out_ff.is_last;
   assign rsp_tuser  = out_ff.status;

endmodule

// ===== rtl/tta_cfg.sv =====
// Size/repeat registers and the registered stride chain derived from them.
module tta_cfg
   import tta_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [EXT_W-1:0]     csr_data,
   output geom_type             geom
);

   ext_type [REG_AXES-1:0] dim_ff;
   ext_type [REG_AXES-1:0] rep_ff;
   idx_type [NUM_AXES-1:0] stride_ff;
   logic [SETTLE_W-1:0]    settle_ff, settle_in;
   ext_type [NUM_AXES-1:0] dim_ax, rep_ax;
   logic                   in_dim_range, in_rep_range;
   logic [CSR_IDX_W-1:0]   rep_slot;

   assign in_dim_range = (csr_index < REG_REP_BASE);
   assign in_rep_range = (csr_index >= REG_REP_BASE) && (csr_index < REG_END);
   assign rep_slot     = csr_index - REG_REP_BASE;

   // axes without a register are size 1, repeat 1
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         if (a < REG_AXES) begin
            dim_ax[a] = dim_ff[a];
            rep_ax[a] = rep_ff[a];
         end else begin
            dim_ax[a] = EXT_W'(1);
            rep_ax[a] = EXT_W'(1);
         end
      end
   end

   always_comb begin
      if (csr_valid) begin
         settle_in = SETTLE_W'(SETTLE_CYCLES);
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - SETTLE_W'(1);
      end else begin
         settle_in = settle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < REG_AXES; a++) begin
            dim_ff[a] <= EXT_W'(1);
            rep_ff[a] <= EXT_W'(1);
         end
         settle_ff <= SETTLE_W'(SETTLE_CYCLES);
      end else begin
         settle_ff <= settle_in;
         // values are stored already clamped to 1..4096
         if (csr_valid && in_dim_range) begin
            dim_ff[csr_index[$clog2(REG_AXES)-1:0]] <= clamp_extent(csr_data);
         end
         if (csr_valid && in_rep_range) begin
            rep_ff[rep_slot[$clog2(REG_AXES)-1:0]] <= clamp_extent(csr_data);
         end
      end
   end

   // one multiply per stage; innermost stride is 1
   always_ff @(posedge clock) begin
      stride_ff[NUM_AXES-1] <= IDX_W'(1);
      for (int a = 0; a < NUM_AXES - 1; a++) begin
         stride_ff[a] <= IDX_W'(stride_ff[a+1] * dim_ax[a+1]);
      end
   end

   assign geom.busy   = (settle_ff != '0);
   assign geom.dim    = dim_ax;
   assign geom.rep    = rep_ax;
   assign geom.stride = stride_ff;

endmodule

// ===== rtl/tta_walk.sv =====
// Walk state: per-axis counters, per-axis source offsets and the next result.
module tta_walk
   import tta_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  geom_type   geom,
   input  logic       step,
   input  logic       restart,
   output result_type result
);

   cnt_type [NUM_AXES-1:0] coord_ff, coord_in, coord_cur;
   cnt_type [NUM_AXES-1:0] rep_ff, rep_in, rep_cur;
   idx_type [NUM_AXES-1:0] part_ff, part_in, part_cur;   // coord * stride per axis
   idx_type                dest_ff, dest_in, dest_cur;
   logic                   finished_ff, finished_in, finished_cur;
   logic [NUM_AXES-1:0]    coord_more, rep_more;
   logic                   last;
   idx_type                src_sum;

   // restart acts on the item that carries it
   always_comb begin
      if (restart) begin
         coord_cur    = '0;
         rep_cur      = '0;
         part_cur     = '0;
         dest_cur     = '0;
         finished_cur = 1'b0;
      end else begin
         coord_cur    = coord_ff;
         rep_cur      = rep_ff;
         part_cur     = part_ff;
         dest_cur     = dest_ff;
         finished_cur = finished_ff;
      end
   end

   always_comb begin
      last    = 1'b1;
      src_sum = '0;
      for (int a = 0; a < NUM_AXES; a++) begin
         coord_more[a] = ({1'b0, coord_cur[a]} + EXT_W'(1)) < geom.dim[a];
         rep_more[a]   = ({1'b0, rep_cur[a]} + EXT_W'(1)) < geom.rep[a];
         if (coord_more[a] || rep_more[a]) begin
            last = 1'b0;
         end
         src_sum = src_sum + part_cur[a];
      end
   end

   // odometer advance, innermost axis first
   always_comb begin
      logic carry;
      carry       = 1'b1;
      coord_in    = coord_cur;
      rep_in      = rep_cur;
      part_in     = part_cur;
      dest_in     = dest_cur;
      finished_in = finished_cur;
      if (!finished_cur) begin
         dest_in = dest_cur + IDX_W'(1);
         if (last) begin
            finished_in = 1'b1;
         end else begin
            for (int a = NUM_AXES - 1; a >= 0; a--) begin
               if (carry) begin
                  if (coord_more[a]) begin
                     coord_in[a] = coord_cur[a] + CNT_W'(1);
                     part_in[a]  = part_cur[a] + geom.stride[a];
                     carry       = 1'b0;
                  end else begin
                     coord_in[a] = '0;
                     part_in[a]  = '0;
                     if (rep_more[a]) begin
                        rep_in[a] = rep_cur[a] + CNT_W'(1);
                        carry     = 1'b0;
                     end else begin
                        rep_in[a] = '0;
                     end
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coord_ff    <= '0;
         rep_ff      <= '0;
         part_ff     <= '0;
         dest_ff     <= '0;
         finished_ff <= 1'b0;
      end else if (step) begin
         coord_ff    <= coord_in;
         rep_ff      <= rep_in;
         part_ff     <= part_in;
         dest_ff     <= dest_in;
         finished_ff <= finished_in;
      end else if (geom.busy) begin
         // strides changed: rebuild offsets from the kept coordinates
         for (int a = 0; a < NUM_AXES; a++) begin
            part_ff[a] <= IDX_W'(coord_ff[a] * geom.stride[a]);
         end
      end
   end

   always_comb begin
      if (finished_cur) begin
         result.dest_index = '0;
         result.src_index  = '0;
         result.is_last    = 1'b0;
         result.status     = STATUS_DONE;
      end else begin
         result.dest_index = dest_cur;
         result.src_index  = src_sum;
         result.is_last    = last;
         result.status     = STATUS_OK;
      end
   end

endmodule

// ===== rtl/tta_checker.sv =====
// Port-level checks for the tensor tile address generator, bound to the top level.
module tta_checker
   import tta_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tready,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [RSP_W-1:0]     rsp_tdata,
   input logic                 rsp_tlast,
   input logic                 rsp_tuser,
   input logic                 csr_valid,
   input logic                 csr_ready
);

   // a held result must not change under back-pressure
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)
         && $stable(rsp_tuser))
      else $error("rsp beat changed while stalled");

   // a register write pauses request intake while strides settle
   assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> !req_tready)
      else $error("request taken right after register write");

   // a done status carries zero addresses and no last flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STATUS_DONE) |-> (rsp_tdata == '0) && !rsp_tlast)
      else $error("done beat carries address data");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("outputs active after reset");

endmodule

bind tensor_tile_address_generator tta_checker u_tta_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready)
);
